// ===== rtl/r2p_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time constant functions for the rect-to-polar block.
package r2p_pkg;

    // Fixed fraction bits of the CORDIC x/y datapath.
    localparam int FRAC_BITS = 16;
    // Angle accumulator width: Q32 radians with headroom and a sign bit.
    localparam int Z_WIDTH = 35;
    // Width of the gain-compensation constant (Q31, always below 1.0).
    localparam int GAIN_WIDTH = 31;

    localparam logic [63:0] PI_Q32         = 64'h0000_0003_243F_6A89;
    localparam logic [63:0] HALF_PI_Q32    = 64'h0000_0001_921F_B544;
    localparam logic [63:0] QUARTER_PI_Q32 = 64'h0000_0000_C90F_DAA2;

    localparam int          DIST_ROUND_SHIFT  = 47;
    localparam logic [63:0] DIST_ROUND_BIAS   = 64'h0000_4000_0000_0000;
    localparam int          ANGLE_ROUND_SHIFT = 19;
    localparam logic [63:0] ANGLE_ROUND_BIAS  = 64'h0000_0000_0004_0000;

    localparam logic [15:0] ANGLE_PI_CODE      = 16'd25736;
    localparam logic [15:0] ANGLE_HALF_PI_CODE = 16'd12868;
    localparam logic [15:0] DIST_MAX           = 16'hFFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_GENERAL,
        KIND_ORIGIN,
        KIND_X_AXIS,
        KIND_Y_AXIS
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  x_neg;
        logic  y_neg;
    } t_tag;

    typedef struct packed {
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    // Unsigned quotient by shift and subtract, one quotient bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          j;
        quo = 64'd0;
        rem = 65'd0;
        for (j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q32, from the odd power series evaluated with 16 guard bits.
    function automatic logic [63:0] atan_q32(input int unsigned i);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        int unsigned k;
        pos = 64'd0;
        neg = 64'd0;
        if (i == 0) begin
            return QUARTER_PI_Q32;
        end
        for (k = 0; i * (2 * k + 1) <= 48; k++) begin
            term = udiv64(64'd1 << (48 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return ((pos - neg) + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        int          j;
        res  = 64'd0;
        rem  = n;
        bitv = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (j = 0; j < 32; j++) begin
            if (bitv != 64'd0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Inverse CORDIC gain in Q31 for the given number of iterations.
    function automatic logic [63:0] gain_k_q31(input int unsigned stages);
        logic [63:0] p;
        int unsigned i;
        p = 64'd1 << 62;
        for (i = 0; i < stages; i++) begin
            p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        return isqrt64(p);
    endfunction

endpackage

// ===== rtl/r2p_front.sv =====
`timescale 1ns / 1ps
// Input side: takes a point, folds it to the first quadrant and classifies axis cases.
module r2p_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  r2p_pkg::t_q_status     i_q_stat,
    output logic                   o_push,
    output logic [COORD_WIDTH-1:0] o_ax,
    output logic [COORD_WIDTH-1:0] o_ay,
    output r2p_pkg::t_tag          o_tag
);

    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;

    assign x_neg  = i_x[COORD_WIDTH-1];
    assign y_neg  = i_y[COORD_WIDTH-1];
    assign x_zero = (i_x == '0);
    assign y_zero = (i_y == '0);

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // The most negative code folds to its magnitude, which still fits unsigned.
    assign o_ax = x_neg ? (COORD_WIDTH'(0) - i_x) : i_x;
    assign o_ay = y_neg ? (COORD_WIDTH'(0) - i_y) : i_y;

    always_comb begin
        o_tag.x_neg = x_neg;
        o_tag.y_neg = y_neg;
        priority if (x_zero && y_zero) begin
            o_tag.kind = r2p_pkg::KIND_ORIGIN;
        end else if (y_zero) begin
            o_tag.kind = r2p_pkg::KIND_X_AXIS;
        end else if (x_zero) begin
            o_tag.kind = r2p_pkg::KIND_Y_AXIS;
        end else begin
            o_tag.kind = r2p_pkg::KIND_GENERAL;
        end
    end

endmodule

// ===== rtl/r2p_queue.sv =====
`timescale 1ns / 1ps
// Small register FIFO between the classifying front and the CORDIC back end.
module r2p_queue #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [COORD_WIDTH-1:0] i_ax,
    input  logic [COORD_WIDTH-1:0] i_ay,
    input  r2p_pkg::t_tag          i_tag,
    input  logic                   i_pop,
    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_ax,
    output logic [COORD_WIDTH-1:0] o_ay,
    output r2p_pkg::t_tag          o_tag,
    output r2p_pkg::t_q_status     o_stat
);

    logic [COORD_WIDTH-1:0]       r_ax_mem  [0:r2p_pkg::Q_DEPTH-1];
    logic [COORD_WIDTH-1:0]       r_ay_mem  [0:r2p_pkg::Q_DEPTH-1];
    r2p_pkg::t_tag                r_tag_mem [0:r2p_pkg::Q_DEPTH-1];
    logic [r2p_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [r2p_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [r2p_pkg::Q_CNT_W-1:0]  r_count;
    logic [r2p_pkg::Q_CNT_W-1:0]  n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ax_mem[r_wr_ptr]  <= i_ax;
            r_ay_mem[r_wr_ptr]  <= i_ay;
            r_tag_mem[r_wr_ptr] <= i_tag;
        end
    end

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_valid      = (r_count != '0);
    assign o_ax         = r_ax_mem[r_rd_ptr];
    assign o_ay         = r_ay_mem[r_rd_ptr];
    assign o_tag        = r_tag_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == r2p_pkg::Q_CNT_W'(r2p_pkg::Q_DEPTH));
    assign o_stat.count = r_count;

endmodule

// ===== rtl/r2p_cordic.sv =====
`timescale 1ns / 1ps
// Back end: unrolled CORDIC vectoring pipeline, gain scaling, rounding and output register.
module r2p_cordic #(
    parameter int STAGES      = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  logic [COORD_WIDTH-1:0] i_ax,
    input  logic [COORD_WIDTH-1:0] i_ay,
    input  r2p_pkg::t_tag          i_tag,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [15:0]            o_distance,
    output logic [15:0]            o_angle
);

    localparam int XW  = COORD_WIDTH + r2p_pkg::FRAC_BITS + 2;
    localparam int CXW = XW - 1;
    localparam int ZW  = r2p_pkg::Z_WIDTH;
    localparam int KW  = r2p_pkg::GAIN_WIDTH;
    localparam int LO  = (CXW + 1) / 2;
    localparam int HI  = CXW - LO;
    localparam int PLW = LO + KW;
    localparam int PHW = HI + KW;
    localparam int SW  = CXW + KW + 1;
    localparam int DW  = SW - r2p_pkg::DIST_ROUND_SHIFT;

    localparam logic [KW-1:0]        GAIN_K  = KW'(r2p_pkg::gain_k_q31(STAGES));
    localparam logic signed [ZW-1:0] HALF_PI = ZW'(r2p_pkg::HALF_PI_Q32);
    localparam logic signed [ZW-1:0] PI_Z    = ZW'(r2p_pkg::PI_Q32);

    logic                  en;

    logic signed [XW-1:0]  r_x   [0:STAGES];
    logic signed [XW-1:0]  r_y   [0:STAGES];
    logic signed [ZW-1:0]  r_z   [0:STAGES];
    r2p_pkg::t_tag         r_tag [0:STAGES];
    logic [STAGES:0]       r_vld;

    logic [CXW-1:0]        cx_clamp;
    logic signed [ZW-1:0]  z_clamp;
    logic signed [ZW-1:0]  z_unfold;
    logic [ZW-1:0]         z_round;

    logic [PLW-1:0]        r_m_plo;
    logic [PHW-1:0]        r_m_phi;
    logic [CXW-1:0]        r_m_cx;
    logic [15:0]           r_m_amag;
    r2p_pkg::t_tag         r_m_tag;
    logic                  r_m_vld;

    logic [SW-1:0]         dist_sum;
    logic [DW-1:0]         dist_full;
    logic [15:0]           n_distance;
    logic [15:0]           n_angle;

    logic [15:0]           r_out_dist;
    logic [15:0]           r_out_ang;
    logic                  r_out_vld;

    // The whole pipe advances unless a finished result is waiting downstream.
    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && i_valid;

    // Axis cases skip the iterations and carry their raw magnitude in x.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= i_tag;
            r_z[0]   <= '0;
            unique case (i_tag.kind)
                r2p_pkg::KIND_GENERAL: begin
                    r_x[0] <= XW'(i_ax) << r2p_pkg::FRAC_BITS;
                    r_y[0] <= XW'(i_ay) << r2p_pkg::FRAC_BITS;
                end
                r2p_pkg::KIND_Y_AXIS: begin
                    r_x[0] <= XW'(i_ay);
                    r_y[0] <= '0;
                end
                default: begin
                    r_x[0] <= XW'(i_ax);
                    r_y[0] <= '0;
                end
            endcase
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(r2p_pkg::atan_q32(s));
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;

        assign sx = r_x[s] >>> s;
        assign sy = r_y[s] >>> s;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag[s+1] <= r_tag[s];
                if (r_tag[s].kind != r2p_pkg::KIND_GENERAL) begin
                    r_x[s+1] <= r_x[s];
                    r_y[s+1] <= r_y[s];
                    r_z[s+1] <= r_z[s];
                end else if (!r_y[s][XW-1]) begin
                    r_x[s+1] <= r_x[s] + sy;
                    r_y[s+1] <= r_y[s] - sx;
                    r_z[s+1] <= r_z[s] + ATAN;
                end else begin
                    r_x[s+1] <= r_x[s] - sy;
                    r_y[s+1] <= r_y[s] + sx;
                    r_z[s+1] <= r_z[s] - ATAN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    // Clamp the final x and angle, unfold and round the angle; gain scaling is split into two narrow partial products.
    always_comb begin
        cx_clamp = r_x[STAGES][XW-1] ? '0 : r_x[STAGES][CXW-1:0];
        priority if (r_z[STAGES][ZW-1]) begin
            z_clamp = '0;
        end else if (r_z[STAGES] > HALF_PI) begin
            z_clamp = HALF_PI;
        end else begin
            z_clamp = r_z[STAGES];
        end
        z_unfold = r_tag[STAGES].x_neg ? (PI_Z - z_clamp) : z_clamp;
        z_round  = z_unfold + ZW'(r2p_pkg::ANGLE_ROUND_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_plo  <= PLW'(cx_clamp[LO-1:0]) * PLW'(GAIN_K);
            r_m_phi  <= PHW'(cx_clamp[CXW-1:LO]) * PHW'(GAIN_K);
            r_m_cx   <= cx_clamp;
            r_m_amag <= 16'(z_round >> r2p_pkg::ANGLE_ROUND_SHIFT);
            r_m_tag  <= r_tag[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_vld[STAGES];
        end
    end

    always_comb begin
        dist_sum  = (SW'(r_m_phi) << LO) + SW'(r_m_plo) + SW'(r2p_pkg::DIST_ROUND_BIAS);
        dist_full = dist_sum[SW-1:r2p_pkg::DIST_ROUND_SHIFT];
        unique case (r_m_tag.kind)
            r2p_pkg::KIND_GENERAL: begin
                n_distance = ((dist_full >> 16) != '0) ? r2p_pkg::DIST_MAX : 16'(dist_full);
                n_angle    = r_m_tag.y_neg ? (16'd0 - r_m_amag) : r_m_amag;
            end
            r2p_pkg::KIND_X_AXIS: begin
                n_distance = ((r_m_cx >> 16) != '0) ? r2p_pkg::DIST_MAX : 16'(r_m_cx);
                n_angle    = r_m_tag.x_neg ? r2p_pkg::ANGLE_PI_CODE : 16'd0;
            end
            r2p_pkg::KIND_Y_AXIS: begin
                n_distance = ((r_m_cx >> 16) != '0) ? r2p_pkg::DIST_MAX : 16'(r_m_cx);
                n_angle    = r_m_tag.y_neg ? (16'd0 - r2p_pkg::ANGLE_HALF_PI_CODE)
                                           : r2p_pkg::ANGLE_HALF_PI_CODE;
            end
            default: begin
                n_distance = 16'd0;
                n_angle    = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_dist <= n_distance;
            r_out_ang  <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_m_vld;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_distance = r_out_dist;
    assign o_angle    = r_out_ang;

endmodule

// ===== rtl/rect_to_polar_converter.sv =====
`timescale 1ns / 1ps
// Top level: Cartesian point in, rounded magnitude and atan2 angle (Q2.13 radians) out.
//
//   Channel   Direction  Handshake                Payload
//   s_axis    in         i_s_tvalid / o_s_tready  x_coord, y_coord
//   m_axis    out        o_m_tvalid / i_m_tready  distance, angle
//
// One point is taken per clock while the queue has room; a result passes the queue, the input
// register, the CORDIC stages, the product register and the output register in that order.
// Throughput is set by the unrolled CORDIC pipeline, one iteration per register stage.
// A held output register freezes the pipeline; a four-entry queue keeps the input open.
// Reset is synchronous, active low, and clears the queue and all pipeline valid bits.
module rect_to_polar_converter #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [COORD_WIDTH-1:0] x_coord, [2*COORD_WIDTH-1:COORD_WIDTH] y_coord, zero pad above
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] distance, [31:16] angle
    output logic [31:0]                 o_m_tdata
);

    logic                   q_push;
    logic                   q_pop;
    logic                   q_valid;
    logic [COORD_WIDTH-1:0] f_ax;
    logic [COORD_WIDTH-1:0] f_ay;
    r2p_pkg::t_tag          f_tag;
    logic [COORD_WIDTH-1:0] q_ax;
    logic [COORD_WIDTH-1:0] q_ay;
    r2p_pkg::t_tag          q_tag;
    r2p_pkg::t_q_status     q_stat;
    logic [15:0]            out_distance;
    logic [15:0]            out_angle;

    r2p_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_x      (i_s_tdata[COORD_WIDTH-1:0]),
        .i_y      (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_ax     (f_ax),
        .o_ay     (f_ay),
        .o_tag    (f_tag)
    );

    r2p_queue #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ax    (f_ax),
        .i_ay    (f_ay),
        .i_tag   (f_tag),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_ax    (q_ax),
        .o_ay    (q_ay),
        .o_tag   (q_tag),
        .o_stat  (q_stat)
    );

    r2p_cordic #(
        .STAGES      (CORDIC_STAGES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_ax       (q_ax),
        .i_ay       (q_ay),
        .i_tag      (q_tag),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_distance (out_distance),
        .o_angle    (out_angle)
    );

    assign o_m_tdata = {out_angle, out_distance};

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= r2p_pkg::Q_CNT_W'(r2p_pkg::Q_DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count missed a write");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_stat.count != '0))
        else $error("back end took an item from an empty queue");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (($signed(o_m_tdata[31:16]) <= $signed(r2p_pkg::ANGLE_PI_CODE))
                     && ($signed(o_m_tdata[31:16]) >= -$signed(r2p_pkg::ANGLE_PI_CODE))))
        else $error("angle result outside minus pi to pi");
`endif

endmodule

// ===== sim/rect_to_polar_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rect-to-polar block: predicts each point's distance and angle and compares.
module rect_to_polar_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [15:0] x_coord, [31:16] y_coord
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] distance, [31:16] angle
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint unsigned QUARTER_PI = 64'h0000_0000_C90F_DAA2;
    localparam longint unsigned HALF_PI    = 64'h0000_0001_921F_B544;
    localparam longint unsigned FULL_PI    = 64'h0000_0003_243F_6A89;
    localparam int              REPORT_MAX = 10;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        distance;
        logic [15:0]        angle;
    } t_polar;

    t_polar          polar_due[$];
    t_polar          oldest;
    longint unsigned atan_table_q32[CORDIC_STAGES];
    longint unsigned inv_gain_q31;
    int              fail_total = 0;

    assign o_fail_count = fail_total;

    // atan(2^-n) in Q32 from the odd power series with 16 guard bits.
    function automatic longint unsigned atan_pow2_q32(input int unsigned n);
        longint unsigned plus_sum;
        longint unsigned minus_sum;
        longint unsigned t;
        int unsigned     d;
        plus_sum  = 0;
        minus_sum = 0;
        if (n == 0) begin
            return QUARTER_PI;
        end
        for (d = 1; n * d <= 48; d += 2) begin
            t = (64'd1 << (48 - n * d)) / d;
            if (((d - 1) / 2) % 2 == 1) begin
                minus_sum += t;
            end else begin
                plus_sum += t;
            end
        end
        return (plus_sum - minus_sum + 64'd32768) >> 16;
    endfunction

    // Largest r with r*r <= v, found bit by bit from the top.
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] angle_to_code(input longint unsigned q32, input bit neg);
        longint unsigned mag;
        mag = (q32 + 64'd262144) >> 19;
        if (neg) begin
            mag = 64'd0 - mag;
        end
        return mag[15:0];
    endfunction

    function automatic t_polar polar_of(input logic [31:0] point);
        t_polar          r;
        longint          xs;
        longint          ys;
        longint          cx;
        longint          cy;
        longint          sx;
        longint          sy;
        longint          z;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned dist_full;
        logic [95:0]     prod;
        int              i;
        r.x = point[15:0];
        r.y = point[31:16];
        xs  = r.x;
        ys  = r.y;
        ax  = (xs < 0) ? -xs : xs;
        ay  = (ys < 0) ? -ys : ys;
        if (xs == 0 && ys == 0) begin
            r.distance = '0;
            r.angle    = '0;
        end else if (ys == 0) begin
            r.distance = (ax > 64'hFFFF) ? 16'hFFFF : ax[15:0];
            r.angle    = angle_to_code((xs > 0) ? 64'd0 : FULL_PI, 1'b0);
        end else if (xs == 0) begin
            r.distance = (ay > 64'hFFFF) ? 16'hFFFF : ay[15:0];
            r.angle    = angle_to_code(HALF_PI, ys < 0);
        end else begin
            // Vectoring in the first quadrant; shifts of negative values floor.
            cx = ax << 16;
            cy = ay << 16;
            z  = 0;
            for (i = 0; i < CORDIC_STAGES; i++) begin
                sx = cx >>> i;
                sy = cy >>> i;
                if (cy >= 0) begin
                    cx += sy;
                    cy -= sx;
                    z  += atan_table_q32[i];
                end else begin
                    cx -= sy;
                    cy += sx;
                    z  -= atan_table_q32[i];
                end
            end
            if (cx < 0) begin
                cx = 0;
            end
            prod      = 96'(cx) * 96'(inv_gain_q31);
            prod      = (prod + (96'd1 << 46)) >> 47;
            dist_full = prod[63:0];
            r.distance = (dist_full > 64'hFFFF) ? 16'hFFFF : dist_full[15:0];
            if (z < 0) begin
                z = 0;
            end
            if (z > longint'(HALF_PI)) begin
                z = HALF_PI;
            end
            if (xs < 0) begin
                z = FULL_PI - z;
            end
            r.angle = angle_to_code(z, ys < 0);
        end
        return r;
    endfunction

    initial begin
        longint unsigned p;
        p = 64'd1 << 62;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            atan_table_q32[i] = atan_pow2_q32(i);
            p = p - p / ((64'd1 << (2 * i)) + 64'd1);
        end
        inv_gain_q31 = root_floor(p);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (polar_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX) begin
                        $display("%0t: result with no point pending: distance %0d angle %0d",
                                 $realtime, i_m_tdata[15:0], $signed(i_m_tdata[31:16]));
                    end
                end else begin
                    oldest = polar_due.pop_front();
                    if (i_m_tdata[15:0] !== oldest.distance ||
                        i_m_tdata[31:16] !== oldest.angle) begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX) begin
                            $display("%0t: point (%0d,%0d): distance exp %0d got %0d, %s%0d got %0d",
                                     $realtime, oldest.x, oldest.y, oldest.distance,
                                     i_m_tdata[15:0], "angle exp ", $signed(oldest.angle),
                                     $signed(i_m_tdata[31:16]));
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                polar_due.push_back(polar_of(i_s_tdata));
            end
            o_pending <= polar_due.size();
        end
    end

endmodule

// ===== sim/rect_to_polar_converter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the rect-to-polar block: clock, reset, point stimulus, result sink and verdict.
module rect_to_polar_converter_tb;

    localparam int STAGES         = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] x_coord, [31:16] y_coord
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] distance, [31:16] angle
    logic [31:0] m_tdata;

    int fail_count;
    int points_pending;
    int idle_cycles = 0;
    bit src_gaps    = 1'b1;
    bit sink_gaps   = 1'b1;
    bit hold_req    = 1'b0;

    // Corners, both axes in both directions, diagonals and alternating bit patterns; {y, x}.
    logic [31:0] corner_points[23] = '{
        32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_0001, 32'h0000_FFFF,
        32'h7FFF_0000, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_7FFF,
        32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF, 32'h0001_0001, 32'hFFFF_FFFF,
        32'hFFFF_0001, 32'h0001_FFFF, 32'h0001_8000, 32'hFFFF_8000, 32'h7FFF_0001,
        32'hAAAA_5555, 32'h5555_AAAA, 32'h0004_FFFD
    };

    rect_to_polar_converter #(
        .CORDIC_STAGES(STAGES),
        .COORD_WIDTH  (16)
    ) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    rect_to_polar_checker #(
        .CORDIC_STAGES(STAGES)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (points_pending)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    // Mostly full-range points, plus tiny vectors, axis and near-axis points and diagonals.
    function automatic logic [31:0] random_point();
        logic [15:0] a;
        logic [15:0] b;
        int unsigned mode;
        mode = $urandom_range(0, 99);
        a    = 16'($urandom);
        b    = 16'($urandom);
        if (mode < 12) begin
            a = 16'($urandom_range(0, 16)) - 16'd8;
            b = 16'($urandom_range(0, 16)) - 16'd8;
        end else if (mode < 20) begin
            if ($urandom_range(0, 1) == 1) begin
                a = '0;
            end else begin
                b = '0;
            end
        end else if (mode < 32) begin
            if ($urandom_range(0, 1) == 1) begin
                a = 16'($urandom_range(0, 6)) - 16'd3;
            end else begin
                b = 16'($urandom_range(0, 6)) - 16'd3;
            end
        end else if (mode < 38) begin
            b = ($urandom_range(0, 1) == 1) ? a : -a;
        end
        return {b, a};
    endfunction

    task automatic push_point(input logic [31:0] point);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= point;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (points_pending != 0);
    endtask

    // Result sink: random stall bursts, plus one long hold that backs the pipeline up.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_points[i]) begin
            push_point(corner_points[i]);
        end
        for (int n = 0; n < 250; n++) begin
            push_point(random_point());
        end

        // Sender waits for every result, then a back-to-back run meets the long sink hold.
        drain_results();
        hold_req = 1'b1;
        src_gaps = 1'b0;
        for (int n = 0; n < 60; n++) begin
            push_point(random_point());
        end
        src_gaps = 1'b1;
        for (int n = 0; n < 190; n++) begin
            push_point(random_point());
        end

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int n = 0; n < 100; n++) begin
            push_point(random_point());
        end

        drain_results();
        repeat (STAGES + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
